### hw/rtl/tch_pkg.sv
package tch_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SQRT, S_VPRE, S_VITER, S_RPRE, S_RITER, S_POST, S_FIN, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    M_AY2, M_AZ2, M_SS_LO, M_SS_HI, M_CS_LO, M_CS_HI,
    M_HX0, M_HX1, M_HX2, M_HY0, M_HY1, M_CD_LO, M_CD_HI
  } mop_e;

  typedef enum logic [1:0] {P_ROLL, P_PITCH, P_HEAD} pass_e;

  localparam logic [1:0] ACT_ABS     = 2'd0;
  localparam logic [1:0] ACT_DELTA   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] CFG_OFF_X = 2'd0;
  localparam logic [1:0] CFG_OFF_Y = 2'd1;
  localparam logic [1:0] CFG_OFF_Z = 2'd2;

  localparam int XW  = 52;  // vectoring x/y
  localparam int ZW  = 34;  // angle accumulator, Q30 sin/cos
  localparam int MAW = 25;  // multiplier port A
  localparam int MBW = 35;  // multiplier port B
  localparam int ACW = 66;  // product accumulator

  localparam longint PI_Q24 = 64'd52707179;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] KINV_Q30    = 34'sd652032874;
  localparam logic [36:0] CD_SCALE = 37'd96126366878;  // 18000/pi in Q24
  localparam int CD_MAX = 18000;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/tilt_compensated_heading.sv
// Tilt-compensated compass heading.
// Input channel (in_valid_i/in_ready_o) takes one beat holding an action code plus raw
// accelerometer and magnetometer samples. Output channel (out_valid_o/out_ready_i)
// returns exactly one beat per input: angle in 0.01 degree and a first-sample flag.
// Hard-iron offsets are written through cfg_we_i/cfg_idx_i/cfg_wdata_i by the user
// only while idle; the block itself does not enforce this. Heading requests run
// one shared CORDIC add/shift unit and one 25x35 multiplier under a sequencer.
// The five CORDIC passes run at one iteration per cycle; an atan2 pass whose
// input vector is zero skips its iterations.
// Restart and unused action codes answer in the cycle after accept.
// One item is in flight at a time: in_ready_o is high only while idle, so no new
// input is taken until the result beat has been taken.
// When the receiver stalls, the result beat holds and no new input is taken.
// Reset clears the offsets, the stored reference heading and its valid flag.
module tilt_compensated_heading #(
  parameter int CORDIC_STEPS = 18,
  parameter int ANGLE_BITS   = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic signed [15:0]  magnet_x_i,
  input  logic signed [15:0]  magnet_y_i,
  input  logic signed [15:0]  magnet_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  angle_centideg_o,
  output logic                first_sample_o
);
  import tch_pkg::*;

  localparam int AW   = ANGLE_BITS;
  localparam int FRAC = ANGLE_BITS - 3;
  localparam int IW   = ($clog2(CORDIC_STEPS) > 4) ? $clog2(CORDIC_STEPS) : 4;
  localparam logic signed [ZW-1:0] PI_F =
    ZW'((PI_Q24 + (longint'(1) << (23 - FRAC))) >> (24 - FRAC));
  localparam logic [ZW-1:0] ATF_RND = ZW'(1) << (29 - FRAC);

  state_e state_q, state_d;
  mop_e   mop_q, mop_d;
  pass_e  pass_q, pass_d;
  logic [IW-1:0] iter_q, iter_d;

  logic [1:0] act_q, act_d;
  logic signed [15:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic signed [16:0] mx_q, mx_d, my_q, my_d, mz_q, mz_d;
  logic signed [15:0] off_x_q, off_x_d, off_y_q, off_y_d, off_z_q, off_z_d;

  logic [31:0] sq_v_q, sq_v_d, sq_r_q, sq_r_d, sq_b_q, sq_b_d;
  logic [15:0] r_q, r_d;

  logic signed [XW-1:0] cx_q, cx_d, cy_q, cy_d, hx_q, hx_d;
  logic signed [ZW-1:0] cz_q, cz_d;
  logic neg_q, neg_d;

  logic signed [AW-1:0] roll_q, roll_d, pitch_q, pitch_d, head_q, head_d, prev_q, prev_d;
  logic hvalid_q, hvalid_d;
  logic signed [ZW-1:0] cr_q, cr_d, sr_q, sr_d, cp_q, cp_d, sp_q, sp_d;
  logic signed [MBW-1:0] t1_q, t1_d, t2_q, t2_d;
  logic signed [ACW-1:0] acc_q, acc_d;
  logic cv_neg_q, cv_neg_d;
  logic [AW-1:0] cv_mag_q, cv_mag_d;
  logic signed [15:0] out_angle_q, out_angle_d;
  logic out_first_q, out_first_d;

  // shared multiplier
  logic signed [MAW-1:0]     mul_a;
  logic signed [MBW-1:0]     mul_b;
  logic signed [MAW+MBW-1:0] mul_p;
  logic                      mul_sh, mul_acc;
  logic signed [ACW-1:0]     mul_term, acc_sum;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = 1'b0;
    mul_acc = 1'b0;
    case (mop_q)
      M_AY2: begin
        mul_a = MAW'(ay_q);
        mul_b = MBW'(ay_q);
      end
      M_AZ2: begin
        mul_a = MAW'(az_q);
        mul_b = MBW'(az_q);
        mul_acc = 1'b1;
      end
      M_SS_LO: begin
        mul_a = MAW'($signed({1'b0, sp_q[16:0]}));
        mul_b = MBW'(sr_q);
      end
      M_SS_HI: begin
        mul_a = MAW'(sp_q >>> 17);
        mul_b = MBW'(sr_q);
        mul_sh = 1'b1;
        mul_acc = 1'b1;
      end
      M_CS_LO: begin
        mul_a = MAW'($signed({1'b0, sp_q[16:0]}));
        mul_b = MBW'(cr_q);
      end
      M_CS_HI: begin
        mul_a = MAW'(sp_q >>> 17);
        mul_b = MBW'(cr_q);
        mul_sh = 1'b1;
        mul_acc = 1'b1;
      end
      M_HX0: begin
        mul_a = MAW'(mx_q);
        mul_b = MBW'(cp_q);
      end
      M_HX1: begin
        mul_a = MAW'(my_q);
        mul_b = t1_q;
        mul_acc = 1'b1;
      end
      M_HX2: begin
        mul_a = MAW'(mz_q);
        mul_b = t2_q;
        mul_acc = 1'b1;
      end
      M_HY0: begin
        mul_a = MAW'(my_q);
        mul_b = MBW'(cr_q);
      end
      M_HY1: begin
        mul_a = -MAW'(mz_q);
        mul_b = MBW'(sr_q);
        mul_acc = 1'b1;
      end
      M_CD_LO: begin
        mul_a = MAW'($signed({1'b0, cv_mag_q}));
        mul_b = MBW'($signed({1'b0, CD_SCALE[16:0]}));
      end
      M_CD_HI: begin
        mul_a = MAW'($signed({1'b0, cv_mag_q}));
        mul_b = MBW'($signed({1'b0, CD_SCALE[36:17]}));
        mul_sh = 1'b1;
        mul_acc = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign mul_term = mul_sh ? (ACW'(mul_p) <<< 17) : ACW'(mul_p);
  assign acc_sum  = (mul_acc ? acc_q : ACW'(0)) + mul_term;

  // shared CORDIC iteration
  logic rot, dirn, cl_last;
  logic signed [XW-1:0] dx, dy, cx_n, cy_n;
  logic signed [ZW-1:0] at, at_rot, at_vec, cz_n;
  logic [31:0] at_tab;

  assign rot     = (state_q == S_RITER);
  assign dx      = cy_q >>> iter_q;
  assign dy      = cx_q >>> iter_q;
  assign at_tab  = atan_q30(5'(iter_q));
  assign at_rot  = $signed(ZW'(at_tab));
  assign at_vec  = $signed((ZW'(at_tab) + ATF_RND) >> (30 - FRAC));
  assign at      = rot ? at_rot : at_vec;
  assign dirn    = rot ? !cz_q[ZW-1] : (cy_q[XW-1] || (cy_q == '0));
  assign cx_n    = dirn ? cx_q - dx : cx_q + dx;
  assign cy_n    = dirn ? cy_q + dy : cy_q - dy;
  assign cz_n    = dirn ? cz_q - at : cz_q + at;
  assign cl_last = (iter_q == IW'(CORDIC_STEPS - 1));

  // square root step
  logic [32:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = {1'b0, sq_r_q} + {1'b0, sq_b_q};
  assign sq_ge  = ({1'b0, sq_v_q} >= sq_sum);

  always_comb begin
    logic signed [XW-1:0] vx, vy;
    logic signed [ZW-1:0] z0, zs;
    logic signed [AW-1:0] vres, ra;
    logic                 vdone;
    logic signed [AW+1:0] dd;
    logic [ACW-1:0]       m;

    state_d = state_q;  mop_d = mop_q;  pass_d = pass_q;  iter_d = iter_q;
    act_d = act_q;  ax_d = ax_q;  ay_d = ay_q;  az_d = az_q;
    mx_d = mx_q;  my_d = my_q;  mz_d = mz_q;
    off_x_d = off_x_q;  off_y_d = off_y_q;  off_z_d = off_z_q;
    sq_v_d = sq_v_q;  sq_r_d = sq_r_q;  sq_b_d = sq_b_q;  r_d = r_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;  neg_d = neg_q;  hx_d = hx_q;
    roll_d = roll_q;  pitch_d = pitch_q;  head_d = head_q;  prev_d = prev_q;
    hvalid_d = hvalid_q;
    cr_d = cr_q;  sr_d = sr_q;  cp_d = cp_q;  sp_d = sp_q;
    t1_d = t1_q;  t2_d = t2_q;  acc_d = acc_q;
    cv_neg_d = cv_neg_q;  cv_mag_d = cv_mag_q;
    out_angle_d = out_angle_q;  out_first_d = out_first_q;
    vx = '0;  vy = '0;  z0 = '0;  zs = '0;  vres = '0;  ra = '0;  vdone = 1'b0;
    dd = '0;  m = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFF_X: off_x_d = $signed(cfg_wdata_i);
        CFG_OFF_Y: off_y_d = $signed(cfg_wdata_i);
        CFG_OFF_Z: off_z_d = $signed(cfg_wdata_i);
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_i;
          ax_d = accel_x_i;
          ay_d = accel_y_i;
          az_d = accel_z_i;
          mx_d = 17'(magnet_x_i) - 17'(off_x_q);
          my_d = 17'(magnet_y_i) - 17'(off_y_q);
          mz_d = 17'(magnet_z_i) - 17'(off_z_q);
          if (action_i == ACT_ABS || action_i == ACT_DELTA) begin
            mop_d = M_AY2;
            state_d = S_MUL;
          end else begin
            if (action_i == ACT_RESTART) hvalid_d = 1'b0;
            out_angle_d = '0;
            out_first_d = 1'b0;
            state_d = S_OUT;
          end
        end
      end
      S_MUL: begin
        acc_d = acc_sum;
        case (mop_q)
          M_AY2:   mop_d = M_AZ2;
          M_AZ2: begin
            sq_v_d = acc_sum[31:0];
            sq_r_d = '0;
            sq_b_d = 32'd1 << 30;
            iter_d = '0;
            state_d = S_SQRT;
          end
          M_SS_LO: mop_d = M_SS_HI;
          M_SS_HI: begin
            t1_d = MBW'(acc_sum >>> 30);
            mop_d = M_CS_LO;
          end
          M_CS_LO: mop_d = M_CS_HI;
          M_CS_HI: begin
            t2_d = MBW'(acc_sum >>> 30);
            mop_d = M_HX0;
          end
          M_HX0:   mop_d = M_HX1;
          M_HX1:   mop_d = M_HX2;
          M_HX2: begin
            hx_d = XW'(acc_sum);
            mop_d = M_HY0;
          end
          M_HY0:   mop_d = M_HY1;
          M_HY1: begin
            pass_d = P_HEAD;
            state_d = S_VPRE;
          end
          M_CD_LO: mop_d = M_CD_HI;
          M_CD_HI: state_d = S_FIN;
          default: state_d = S_IDLE;
        endcase
      end
      S_SQRT: begin
        sq_v_d = sq_ge ? sq_v_q - sq_sum[31:0] : sq_v_q;
        sq_r_d = sq_ge ? (sq_r_q >> 1) + sq_b_q : sq_r_q >> 1;
        sq_b_d = sq_b_q >> 2;
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(15)) begin
          r_d = sq_r_d[15:0];
          pass_d = P_ROLL;
          state_d = S_VPRE;
        end
      end
      S_VPRE: begin
        case (pass_q)
          P_ROLL: begin
            vy = XW'(ay_q);
            vx = XW'(az_q);
          end
          P_PITCH: begin
            vy = -XW'(ax_q);
            vx = XW'($signed({1'b0, r_q}));
          end
          default: begin
            vy = -XW'(acc_q);
            vx = hx_q;
          end
        endcase
        iter_d = '0;
        if (vx == '0 && vy == '0) begin
          vdone = 1'b1;
          vres = '0;
        end else if (vx[XW-1]) begin
          cz_d = vy[XW-1] ? -PI_F : PI_F;
          cx_d = -vx;
          cy_d = -vy;
          state_d = S_VITER;
        end else begin
          cz_d = '0;
          cx_d = vx;
          cy_d = vy;
          state_d = S_VITER;
        end
      end
      S_VITER: begin
        cx_d = cx_n;
        cy_d = cy_n;
        cz_d = cz_n;
        iter_d = iter_q + 1'b1;
        if (cl_last) begin
          zs = cz_n;
          if (zs > PI_F) zs = PI_F;
          if (zs < -PI_F) zs = -PI_F;
          vres = AW'(zs);
          vdone = 1'b1;
        end
      end
      S_RPRE: begin
        ra = (pass_q == P_ROLL) ? roll_q : pitch_q;
        z0 = ZW'(ra) <<< (30 - FRAC);
        neg_d = 1'b0;
        if (z0 > HALF_PI_Q30) begin
          z0 = z0 - PI_Q30;
          neg_d = 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
          z0 = z0 + PI_Q30;
          neg_d = 1'b1;
        end
        cz_d = z0;
        cx_d = XW'(KINV_Q30);
        cy_d = '0;
        iter_d = '0;
        state_d = S_RITER;
      end
      S_RITER: begin
        cx_d = cx_n;
        cy_d = cy_n;
        cz_d = cz_n;
        iter_d = iter_q + 1'b1;
        if (cl_last) begin
          if (pass_q == P_ROLL) begin
            cr_d = ZW'(neg_q ? -cx_n : cx_n);
            sr_d = ZW'(neg_q ? -cy_n : cy_n);
            pass_d = P_PITCH;
            state_d = S_RPRE;
          end else begin
            cp_d = ZW'(neg_q ? -cx_n : cx_n);
            sp_d = ZW'(neg_q ? -cy_n : cy_n);
            mop_d = M_SS_LO;
            state_d = S_MUL;
          end
        end
      end
      S_POST: begin
        if (act_q == ACT_DELTA && !hvalid_q) begin
          prev_d = head_q;
          hvalid_d = 1'b1;
          out_angle_d = '0;
          out_first_d = 1'b1;
          state_d = S_OUT;
        end else begin
          if (act_q == ACT_DELTA) begin
            dd = (AW+2)'(head_q) - (AW+2)'(prev_q);
            if (dd > (AW+2)'(PI_F)) dd = dd - ((AW+2)'(PI_F) <<< 1);
            if (dd < -(AW+2)'(PI_F)) dd = dd + ((AW+2)'(PI_F) <<< 1);
            prev_d = head_q;
          end else begin
            dd = (AW+2)'(head_q);
          end
          cv_neg_d = dd[AW+1];
          cv_mag_d = AW'(dd[AW+1] ? -dd : dd);
          mop_d = M_CD_LO;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        m = $unsigned(acc_q) >> (24 + FRAC);
        if (m > ACW'(CD_MAX)) m = ACW'(CD_MAX);
        out_angle_d = cv_neg_q ? -$signed(16'(m)) : $signed(16'(m));
        out_first_d = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (vdone) begin
      case (pass_q)
        P_ROLL: begin
          roll_d = vres;
          pass_d = P_PITCH;
          state_d = S_VPRE;
        end
        P_PITCH: begin
          pitch_d = vres;
          pass_d = P_ROLL;
          state_d = S_RPRE;
        end
        default: begin
          head_d = vres;
          state_d = S_POST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      off_x_q  <= '0;
      off_y_q  <= '0;
      off_z_q  <= '0;
      prev_q   <= '0;
      hvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      off_z_q  <= off_z_d;
      prev_q   <= prev_d;
      hvalid_q <= hvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mop_q <= mop_d;  pass_q <= pass_d;  iter_q <= iter_d;
    act_q <= act_d;  ax_q <= ax_d;  ay_q <= ay_d;  az_q <= az_d;
    mx_q <= mx_d;  my_q <= my_d;  mz_q <= mz_d;
    sq_v_q <= sq_v_d;  sq_r_q <= sq_r_d;  sq_b_q <= sq_b_d;  r_q <= r_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;  neg_q <= neg_d;  hx_q <= hx_d;
    roll_q <= roll_d;  pitch_q <= pitch_d;  head_q <= head_d;
    cr_q <= cr_d;  sr_q <= sr_d;  cp_q <= cp_d;  sp_q <= sp_d;
    t1_q <= t1_d;  t2_q <= t2_d;  acc_q <= acc_d;
    cv_neg_q <= cv_neg_d;  cv_mag_q <= cv_mag_d;
    out_angle_q <= out_angle_d;  out_first_q <= out_first_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign angle_centideg_o = out_angle_q;
  assign first_sample_o   = out_first_q;

endmodule

### hw/rtl/tch_checker.sv
module tch_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         action_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] angle_centideg_o,
  input logic               first_sample_o
);
  import tch_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_centideg_o)
      && $stable(first_sample_o))
    else $error("result beat changed while stalled");

  // one beat in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_sample_o |-> angle_centideg_o == 16'sd0)
    else $error("first sample with nonzero angle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_centideg_o <= 16'sd18000 && angle_centideg_o >= -16'sd18000)
    else $error("angle out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_RESTART |=>
      out_valid_o && angle_centideg_o == 16'sd0 && !first_sample_o)
    else $error("restart beat wrong");

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .action_i         (action_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .angle_centideg_o (angle_centideg_o),
  .first_sample_o   (first_sample_o)
);

### bench/heading_checker.sv
`timescale 1ns / 100ps

module heading_checker #(
  parameter int STEPS = 18,
  parameter int ABITS = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] magnet_x_i,
  input  logic signed [15:0] magnet_y_i,
  input  logic signed [15:0] magnet_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] angle_centideg_i,
  input  logic               first_sample_i,
  output int                 errors_o,
  output int                 pending_o
);
  import tch_pkg::*;

  localparam int FB = ABITS - 3;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               first;
  } heading_res_t;

  localparam longint ARCTAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  heading_res_t       expected_q[$];
  logic signed [15:0] off_x, off_y, off_z;
  longint             ref_heading;
  logic               ref_valid;

  assign pending_o = expected_q.size();

  function automatic int n_steps();
    return (STEPS > 24) ? 24 : STEPS;
  endfunction

  function automatic longint pi_fix();
    return (longint'(PI_Q24) + (longint'(1) << (23 - FB))) >>> (24 - FB);
  endfunction

  function automatic longint arctan_fix(int i);
    return (ARCTAN_Q30[i % 24] + (longint'(1) << (29 - FB))) >>> (30 - FB);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint z, pi, dx, dy;
    z  = 0;
    pi = pi_fix();
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? pi : -pi;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n_steps(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_fix(i);
      end else begin
        x -= dx; y += dy; z -= arctan_fix(i);
      end
    end
    if (z > pi) z = pi;
    if (z < -pi) z = -pi;
    return z;
  endfunction

  function automatic void rot_sincos(input longint a, output longint c, output longint s);
    longint z, x, y, dx, dy;
    logic   flip;
    z    = a * (longint'(1) << (30 - FB));
    x    = longint'(KINV_Q30);
    y    = 0;
    flip = 1'b0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30); flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30); flip = 1'b1;
    end
    for (int i = 0; i < n_steps(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_Q30[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] to_centideg(longint a);
    longint m;
    m = (a < 0) ? -a : a;
    m = longint'((longint'(m) * longint'(CD_SCALE)) >>> (24 + FB));
    if (m > CD_MAX) m = CD_MAX;
    return (a < 0) ? 16'(-m) : 16'(m);
  endfunction

  function automatic longint tilt_heading(longint ax, longint ay, longint az,
                                          longint mx, longint my, longint mz);
    longint r, roll, pitch, cr, sr, cp, sp, hx, hy;
    r     = int_sqrt(ay * ay + az * az);
    roll  = vec_atan2(ay, az);
    pitch = vec_atan2(-ax, r);
    rot_sincos(roll, cr, sr);
    rot_sincos(pitch, cp, sp);
    hx = mx * cp + my * ((sr * sp) >>> 30) + mz * ((cr * sp) >>> 30);
    hy = my * cr - mz * sr;
    return vec_atan2(-hy, hx);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("checker: %s mismatch got %0d want %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint       h, d;
    heading_res_t e, got;
    if (!rst_ni) begin
      off_x       <= '0;
      off_y       <= '0;
      off_z       <= '0;
      ref_heading <= 0;
      ref_valid   <= 1'b0;
      expected_q.delete();
      errors_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFF_X: off_x <= cfg_wdata_i;
          CFG_OFF_Y: off_y <= cfg_wdata_i;
          CFG_OFF_Z: off_z <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.angle = angle_centideg_i;
        got.first = first_sample_i;
        if (expected_q.size() == 0) begin
          report("unexpected beat", got.angle, 0);
        end else begin
          e = expected_q.pop_front();
          if (got.angle !== e.angle) report("angle", got.angle, e.angle);
          if (got.first !== e.first) report("first_sample", got.first, e.first);
        end
      end
      if (in_valid_i && in_ready_i) begin
        e = '0;
        if (action_i == ACT_ABS || action_i == ACT_DELTA)
          h = tilt_heading(accel_x_i, accel_y_i, accel_z_i,
                           longint'(magnet_x_i) - off_x, longint'(magnet_y_i) - off_y,
                           longint'(magnet_z_i) - off_z);
        if (action_i == ACT_ABS) begin
          e.angle = to_centideg(h);
        end else if (action_i == ACT_DELTA) begin
          if (!ref_valid) begin
            e.first = 1'b1;
          end else begin
            d = h - ref_heading;
            if (d > pi_fix()) d -= 2 * pi_fix();
            if (d < -pi_fix()) d += 2 * pi_fix();
            e.angle = to_centideg(d);
          end
          ref_heading <= h;
          ref_valid   <= 1'b1;
        end else if (action_i == ACT_RESTART) begin
          ref_valid <= 1'b0;
        end
        expected_q.push_back(e);
      end
    end
  end
endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import tch_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] CFG_NONE   = 2'd3;
  localparam int         LIMIT      = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i = '0;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] magnet_x_i = '0, magnet_y_i = '0, magnet_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] angle_centideg_o;
  logic               first_sample_o;
  int                 errors, pending, cycles;
  logic               steady = 1'b0;

  always #1 clk_i = ~clk_i;

  tilt_compensated_heading dut (.*);

  heading_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i,
    .accel_x_i, .accel_y_i, .accel_z_i, .magnet_x_i, .magnet_y_i, .magnet_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .angle_centideg_i(angle_centideg_o),
    .first_sample_i(first_sample_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk_i iff rst_ni);
    forever begin
      n = steady ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(logic [1:0] act, logic signed [15:0] ax, ay, az, mx, my, mz);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i   <= act;
    accel_x_i  <= ax;
    accel_y_i  <= ay;
    accel_z_i  <= az;
    magnet_x_i <= mx;
    magnet_y_i <= my;
    magnet_z_i <= mz;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_offsets(logic [15:0] ox, oy, oz);
    write_reg(CFG_OFF_X, ox);
    write_reg(CFG_OFF_Y, oy);
    write_reg(CFG_OFF_Z, oz);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int count);
    logic [1:0] act;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0:       act = ACT_RESTART;
        1:       act = ACT_UNUSED;
        2, 3, 4, 5, 6, 7, 8: act = ACT_ABS;
        default: act = ACT_DELTA;
      endcase
      if (k % 100 == 50) steady = 1'b1;
      if (k % 100 == 70) steady = 1'b0;
      if (k == count / 2) drain();
      send(act, sample(), sample(), sample(), sample(), sample(), sample());
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ACT_DELTA,   0, 0, 16384, 1000, 0, 0);
    send(ACT_DELTA,   0, 0, 16384, 0, 1000, 0);
    send(ACT_DELTA,   0, 0, 16384, -1000, 0, 0);
    send(ACT_DELTA,   0, 0, 16384, 0, -1000, 0);
    send(ACT_DELTA,   0, 0, 16384, -1000, 10, 0);
    send(ACT_DELTA,   0, 0, 16384, -1000, -10, 0);
    send(ACT_ABS,     0, 0, 0, 0, 0, 0);
    send(ACT_ABS,     16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send(ACT_ABS,     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(ACT_ABS,     16'sh8000, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send(ACT_ABS,     16'sh7FFF, 0, 16'sh8000, -5, 7, 16'sh8000);
    send(ACT_ABS,     0, 16'sh8000, 0, 300, -200, 100);
    send(ACT_ABS,     0, 0, -16384, 500, 500, 500);
    send(ACT_RESTART, 1, 2, 3, 4, 5, 6);
    send(ACT_DELTA,   0, 0, 16384, 1000, 1000, 0);
    send(ACT_DELTA,   0, 0, 16384, -1000, -1000, 0);
    send(ACT_UNUSED,  16'sh7FFF, 16'sh8000, 1, -1, 16'sh7FFF, 16'sh8000);
    send(ACT_DELTA,   16'sh8000, 16'sh7FFF, 0, 0, 0, 0);
    send(ACT_RESTART, 0, 0, 0, 0, 0, 0);
    send(ACT_RESTART, 0, 0, 0, 0, 0, 0);
    send(ACT_DELTA,   100, -100, 16000, 16'sh7FFF, 0, 0);
    drain();

    random_run(400);
    set_offsets(16'h7FFF, 16'h8000, 16'h0000);
    send(ACT_ABS, 0, 0, 16384, 16'sh7FFF, 16'sh8000, 0);
    random_run(330);
    set_offsets(16'h8000, 16'h7FFF, 16'h8000);
    write_reg(CFG_NONE, 16'h1234);
    cfg_we_i <= 1'b0;
    random_run(330);
    set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
    random_run(330);

    repeat (150) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
